// ===== hw/rtl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types, constants and arithmetic helpers of the PCM sample mixer.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int VOICES_DEF       = 16;
    localparam int SAMPLE_DEPTH_DEF = 16384;
    localparam int MIX_RATE         = 44100;

    // step = floor(rate * 2^16 / MIX_RATE) = (rate * STEP_M) >> 30
    localparam logic [30:0] STEP_M =
        31'(((64'd1 << 46) + 64'(MIX_RATE) - 64'd1) / 64'(MIX_RATE));
    // floor(x / 127) = (x * DIV127_M) >> 22 for x below 2^15
    localparam logic [15:0] DIV127_M = 16'(((64'd1 << 22) + 64'd126) / 64'd127);
    // floor(x / 255) = (x * DIV255_M) >> 32 for x below 2^24
    localparam logic [24:0] DIV255_M = 25'(((64'd1 << 32) + 64'd254) / 64'd255);

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_START  = 3'd1,
        CMD_GAINS  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_MIX    = 3'd4,
        CMD_QUERY  = 3'd5
    } mpsm_cmd_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  voice;
        logic [13:0] sample_address;
        logic [7:0]  sample_byte;
        logic [14:0] sound_length;
        logic [15:0] source_rate;
        logic [6:0]  volume;
        logic [7:0]  separation;
    } mpsm_item_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               is_playing;
        logic               accepted;
    } mpsm_result_t;

    // Command broadcast to every voice cell
    typedef struct packed {
        logic        start;
        logic        set_gain;
        logic        stop;
        logic [3:0]  voice;
        logic [14:0] length;
        logic [16:0] step;
        logic [7:0]  lgain;
        logic [7:0]  rgain;
    } mpsm_ctl_t;

    // What the cell holding the mix token shows to the mix pipeline
    typedef struct packed {
        logic        valid;
        logic        live;
        logic [5:0]  vid;
        logic [15:0] idx;
        logic [7:0]  lgain;
        logic [7:0]  rgain;
    } mpsm_tap_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  voice;
        logic [13:0] addr;
        logic [7:0]  data;
    } mpsm_wr_t;

    function automatic logic [7:0] div127(input logic [14:0] x);
        logic [30:0] p;
        begin
            p = 31'(x) * 31'(DIV127_M);
            return p[29:22];
        end
    endfunction

endpackage

// ===== hw/rtl/mpsm_voice_cell.sv =====
// ----------------------------------------------------------------------------
// mpsm_voice_cell
// State of one voice; passes the mix token on to the next cell.
// ----------------------------------------------------------------------------
module mpsm_voice_cell #(
    parameter int CELL_ID = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              token_in,
    output logic              token_out,
    input  mpsm_pkg::mpsm_ctl_t ctl,
    output logic              active,
    output mpsm_pkg::mpsm_tap_t tap
);
    import mpsm_pkg::*;

    logic        token_reg;
    logic        active_reg, active_next;
    logic [31:0] pos_reg, pos_next;
    logic [16:0] step_reg, step_next;
    logic [14:0] len_reg, len_next;
    logic [7:0]  gl_reg, gl_next;
    logic [7:0]  gr_reg, gr_next;
    logic        hit;
    logic        expire;

    assign hit    = {2'b00, ctl.voice} == 6'(CELL_ID);
    assign expire = pos_reg[31:16] >= {1'b0, len_reg};

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        step_next   = step_reg;
        len_next    = len_reg;
        gl_next     = gl_reg;
        gr_next     = gr_reg;
        // mix visit: drop a finished voice, else advance
        if (token_reg && active_reg)
        begin
            if (expire)
            begin
                active_next = 1'b0;
                pos_next    = '0;
                step_next   = '0;
                len_next    = '0;
                gl_next     = '0;
                gr_next     = '0;
            end
            else
            begin
                pos_next = pos_reg + 32'(step_reg);
            end
        end
        if (hit)
        begin
            priority if (ctl.stop)
            begin
                active_next = 1'b0;
                pos_next    = '0;
                step_next   = '0;
                len_next    = '0;
                gl_next     = '0;
                gr_next     = '0;
            end
            else if (ctl.start)
            begin
                active_next = 1'b1;
                pos_next    = '0;
                step_next   = ctl.step;
                len_next    = ctl.length;
                gl_next     = ctl.lgain;
                gr_next     = ctl.rgain;
            end
            else if (ctl.set_gain)
            begin
                gl_next = ctl.lgain;
                gr_next = ctl.rgain;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg  <= 1'b0;
            active_reg <= 1'b0;
            pos_reg    <= '0;
            step_reg   <= '0;
            len_reg    <= '0;
            gl_reg     <= '0;
            gr_reg     <= '0;
        end
        else
        begin
            token_reg  <= token_in;
            active_reg <= active_next;
            pos_reg    <= pos_next;
            step_reg   <= step_next;
            len_reg    <= len_next;
            gl_reg     <= gl_next;
            gr_reg     <= gr_next;
        end
    end

    assign token_out = token_reg;
    assign active    = active_reg;

    always_comb
    begin
        tap = '0;
        if (token_reg)
        begin
            tap.valid = 1'b1;
            tap.live  = active_reg && !expire;
            tap.vid   = 6'(CELL_ID);
            tap.idx   = pos_reg[31:16];
            tap.lgain = gl_reg;
            tap.rgain = gr_reg;
        end
    end

endmodule

// ===== hw/rtl/mpsm_mix_pipe.sv =====
// ----------------------------------------------------------------------------
// mpsm_mix_pipe
// Sample store, per-voice scaling pipeline and the stereo accumulator.
// ----------------------------------------------------------------------------
module mpsm_mix_pipe #(
    parameter int VOICES       = mpsm_pkg::VOICES_DEF,
    parameter int SAMPLE_DEPTH = mpsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mpsm_pkg::mpsm_wr_t  wr,
    input  mpsm_pkg::mpsm_tap_t tap,
    input  logic                tap_last,
    output logic                done,
    output logic signed [15:0]  left,
    output logic signed [15:0]  right
);
    import mpsm_pkg::*;

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int ACC_W = 17 + $clog2(VOICES);
    localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] NEG_LIM = ~POS_LIM;

    logic [7:0] mem [VOICES][SAMPLE_DEPTH];

    // stage 1: store read
    logic       v1_reg, last1_reg, live1_reg;
    logic [7:0] data1_reg, gl1_reg, gr1_reg;
    // stage 2: magnitude times gain
    logic        v2_reg, last2_reg, live2_reg, neg2_reg;
    logic [15:0] pl2_reg, pr2_reg;
    // stage 3: times 256, divided by 255
    logic        v3_reg, last3_reg, live3_reg, neg3_reg;
    logic [15:0] ql3_reg, qr3_reg;
    // stage 4: accumulate
    logic signed [ACC_W-1:0] accl_reg, accr_reg;
    logic signed [ACC_W-1:0] cl, cr, suml, sumr;
    logic                    done_reg;
    logic signed [15:0]      left_reg, right_reg;

    logic [7:0]  mag;
    logic [48:0] prodl, prodr;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[VW'(wr.voice)][AW'(wr.addr)] <= wr.data;
        data1_reg <= mem[VW'(tap.vid)][AW'(tap.idx)];
        gl1_reg   <= tap.lgain;
        gr1_reg   <= tap.rgain;
        live1_reg <= tap.live;
        last1_reg <= tap_last;
    end

    assign mag = data1_reg[7] ? (data1_reg - 8'd128) : (8'd128 - data1_reg);

    always_ff @(posedge clk)
    begin
        pl2_reg   <= 16'(mag) * 16'(gl1_reg);
        pr2_reg   <= 16'(mag) * 16'(gr1_reg);
        neg2_reg  <= !data1_reg[7];
        live2_reg <= live1_reg;
        last2_reg <= last1_reg;
    end

    assign prodl = 49'({pl2_reg, 8'h00}) * 49'(DIV255_M);
    assign prodr = 49'({pr2_reg, 8'h00}) * 49'(DIV255_M);

    always_ff @(posedge clk)
    begin
        ql3_reg   <= prodl[47:32];
        qr3_reg   <= prodr[47:32];
        neg3_reg  <= neg2_reg;
        live3_reg <= live2_reg;
        last3_reg <= last2_reg;
    end

    always_comb
    begin
        cl = '0;
        cr = '0;
        if (live3_reg)
        begin
            cl = neg3_reg ? -$signed(ACC_W'(ql3_reg)) : $signed(ACC_W'(ql3_reg));
            cr = neg3_reg ? -$signed(ACC_W'(qr3_reg)) : $signed(ACC_W'(qr3_reg));
        end
        suml = accl_reg + cl;
        sumr = accr_reg + cr;
    end

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
        begin
            if (x > POS_LIM)
                return 16'sh7FFF;
            else if (x < NEG_LIM)
                return 16'sh8000;
            else
                return 16'(x);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            accl_reg <= '0;
            accr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= tap.valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg && last3_reg;
            if (v3_reg)
            begin
                if (last3_reg)
                begin
                    accl_reg <= '0;
                    accr_reg <= '0;
                end
                else
                begin
                    accl_reg <= suml;
                    accr_reg <= sumr;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && last3_reg)
        begin
            left_reg  <= sat16(suml);
            right_reg <= sat16(sumr);
        end
    end

    assign done  = done_reg;
    assign left  = left_reg;
    assign right = right_reg;

endmodule

// ===== hw/rtl/multichannel_pcm_sample_mixer_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_pcm_sample_mixer_core
// Stereo mixer for up to VOICES voices of unsigned 8-bit sampled sound.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item) takes one command per
//   transfer: write a sample byte, start, set gains, stop, query or mix tick.
//   result channel (result_valid / result_stall / result) returns exactly one
//   result per command, in order.
// Timing and throughput:
//   every command except the mix tick answers in the cycle after its transfer,
//   and a new command is taken in the cycle its result leaves.
//   A mix tick passes a token down the chain of voice cells, one cell per
//   cycle; each visited voice reads one byte from the single store port and
//   runs through a four-stage pipeline that scales it and adds it to the sums.
// Reset: all voices idle with zeroed position, step, length and gains; the
//   sample store is not cleared and holds garbage until written.
// Stall: a stalled result holds; no new command is taken until it transfers.
//   A finished mix tick waits in a hold state until the result slot frees.
// ----------------------------------------------------------------------------
module multichannel_pcm_sample_mixer_core #(
    parameter int VOICES       = mpsm_pkg::VOICES_DEF,
    parameter int SAMPLE_DEPTH = mpsm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  mpsm_pkg::mpsm_item_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mpsm_pkg::mpsm_result_t result
);
    import mpsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MIX  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic         take;
    logic         slot_free;
    logic         voice_ok;
    logic         is_mix;
    mpsm_ctl_t    ctl;
    mpsm_wr_t     wr;
    logic [VOICES-1:0] token;
    logic [VOICES-1:0] active;
    mpsm_tap_t    taps [VOICES];
    mpsm_tap_t    tap_all;
    logic         mix_done;
    logic signed [15:0] mix_left, mix_right;
    logic [46:0]  step_prod;
    logic [16:0]  step_raw;
    logic [7:0]   left_weight;
    logic         query_hit;

    logic         result_valid_reg, result_valid_next;
    mpsm_result_t result_reg, result_next;

    // The result slot can load when it is empty or its transfer happens now
    assign slot_free  = !result_valid_reg || !result_stall;
    // Take a command only when idle and the result slot frees this cycle
    assign item_stall = (state_reg != ST_IDLE) || !slot_free;
    assign take       = item_valid && !item_stall;
    assign voice_ok   = 7'(item.voice) < 7'(VOICES);
    assign is_mix     = item.command == CMD_MIX;

    // Step from source rate, never below one
    assign step_prod   = 47'(item.source_rate) * 47'(STEP_M);
    assign step_raw    = (step_prod[46:30] == 17'd0) ? 17'd1 : step_prod[46:30];
    assign left_weight = 8'd254 - item.separation;

    always_comb
    begin
        ctl          = '0;
        ctl.voice    = item.voice;
        ctl.length   = (32'(item.sound_length) > 32'(SAMPLE_DEPTH))
                       ? 15'(SAMPLE_DEPTH) : item.sound_length;
        ctl.step     = step_raw;
        // separation past full right makes the left weight negative: clamp to 0
        ctl.lgain    = (item.separation == 8'd255) ? 8'd0
                       : div127(15'(left_weight) * 15'(item.volume));
        ctl.rgain    = div127(15'(item.separation) * 15'(item.volume));
        ctl.start    = take && item.command == CMD_START && item.source_rate != 16'd0;
        ctl.set_gain = take && item.command == CMD_GAINS;
        ctl.stop     = take && item.command == CMD_STOP;
    end

    always_comb
    begin
        wr      = '0;
        wr.en   = take && item.command == CMD_WRITE && voice_ok
                  && (32'(item.sample_address) < 32'(SAMPLE_DEPTH));
        wr.voice = item.voice;
        wr.addr  = item.sample_address;
        wr.data  = item.sample_byte;
    end

    // Chain of voice cells; the token enters cell 0 on a mix tick
    for (genvar i = 0; i < VOICES; i++)
    begin : g_cell
        logic tin;
        if (i == 0)
        begin : g_head
            assign tin = take && is_mix;
        end
        else
        begin : g_link
            assign tin = token[i-1];
        end
        mpsm_voice_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .token_in  (tin),
            .token_out (token[i]),
            .ctl       (ctl),
            .active    (active[i]),
            .tap       (taps[i])
        );
    end

    // Only the cell holding the token drives a nonzero tap
    always_comb
    begin
        tap_all   = '0;
        query_hit = 1'b0;
        for (int i = 0; i < VOICES; i++)
        begin
            tap_all = tap_all | taps[i];
            if (7'(item.voice) == 7'(i))
                query_hit = active[i];
        end
    end

    mpsm_mix_pipe #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .tap      (tap_all),
        .tap_last (token[VOICES-1]),
        .done     (mix_done),
        .left     (mix_left),
        .right    (mix_right)
    );

    // Hold a finished mix while the previous result is still stalled;
    // the pipeline output registers keep the sums until the next tick.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && is_mix)
                    state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (mix_done)
                    state_next = slot_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result slot: load on a finished command, clear on transfer
    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
        if (take && !is_mix)
        begin
            result_valid_next       = 1'b1;
            result_next.left_sample  = '0;
            result_next.right_sample = '0;
            result_next.is_playing   = item.command == CMD_QUERY && query_hit;
            result_next.accepted     = !(item.command == CMD_START && voice_ok
                                         && item.source_rate == 16'd0);
        end
        else if (((state_reg == ST_MIX && mix_done) || state_reg == ST_HOLD)
                 && slot_free)
        begin
            result_valid_next        = 1'b1;
            result_next.left_sample  = mix_left;
            result_next.right_sample = mix_right;
            result_next.is_playing   = 1'b0;
            result_next.accepted     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hw/rtl/mpsm_checker.sv =====
// ----------------------------------------------------------------------------
// mpsm_checker
// Port-level checks of the mixer core, bound to the top level.
// ----------------------------------------------------------------------------
module mpsm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input mpsm_pkg::mpsm_item_t   item,
    input logic                   result_valid,
    input logic                   result_stall,
    input mpsm_pkg::mpsm_result_t result
);
    import mpsm_pkg::*;

    // Non-mix commands answer in the next cycle
    a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.command != CMD_MIX |=> result_valid)
        else $error("non-mix command did not answer next cycle");

    // Zero-rate start to a voice in range is reported as rejected
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.command == CMD_START
        && 7'(item.voice) < 7'(VOICES_DEF) && item.source_rate == 16'd0
        |=> result_valid && !result.accepted)
        else $error("zero-rate start not rejected");

    // No transfer in while a result is held back
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("command taken while result stalled");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind multichannel_pcm_sample_mixer_core mpsm_checker u_mpsm_checker (.*);
